// ===== hw/rtl/dsfd_pkg.sv =====
// shared types, constants and the crc step for the dle stuffed frame decoder
// no dependencies
`timescale 1ns / 1ps

package dsfd_pkg;

  // decoded data byte counter width
  localparam int COUNT_BITS = 16;
  localparam int COUNT_OUT_BITS = 16;
  localparam int CAP_BITS = 16;

  // result queue between decoder and emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // control symbols
  localparam logic [7:0] DLE_CODE = 8'h10;
  localparam logic [7:0] STX_CODE = 8'h02;
  localparam logic [7:0] ETX_CODE = 8'h03;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // shortest buffer: start pair, end pair and the check bytes
  localparam logic [2:0] MIN_LEN_BCC = 3'd5;
  localparam logic [2:0] MIN_LEN_CRC = 3'd6;
  localparam logic [2:0] WIRE_CNT_MAX = 3'd6;

  // configuration register indexes
  localparam logic CFG_USE_CRC = 1'b0;
  localparam logic CFG_DATA_CAP = 1'b1;

  typedef enum logic [2:0] {
    PH_START0,
    PH_START1,
    PH_DATA,
    PH_ESC,
    PH_CHK0,
    PH_CHK1,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_BADSTART = 3'd2,
    ST_BADCTRL  = 3'd3,
    ST_OVERFLOW = 3'd4,
    ST_NOEND    = 3'd5,
    ST_NOCHECK  = 3'd6,
    ST_MISMATCH = 3'd7
  } status_e;

  // one queue entry: the results caused by one wire byte
  typedef struct packed {
    logic                      has_data;
    logic [7:0]                data_byte;
    logic                      has_verdict;
    status_e                   status;
    logic [COUNT_OUT_BITS-1:0] count;
  } entry_t;

  // reflected crc-16 update over one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/dsfd_if.sv =====
// handshake channel interfaces: wire bytes in, results out, register writes
// depends on dsfd_pkg
`timescale 1ns / 1ps

interface dsfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] wire_byte;
  logic       buffer_end;
  modport source (output valid, output wire_byte, output buffer_end, input ready);
  modport sink (input valid, input wire_byte, input buffer_end, output ready);
endinterface

interface dsfd_out_if;
  logic        valid;
  logic        ready;
  logic        is_verdict;
  logic [7:0]  data_byte;
  logic [2:0]  status;
  logic [15:0] data_count;
  modport source (output valid, output is_verdict, output data_byte, output status,
                  output data_count, input ready);
  modport sink (input valid, input is_verdict, input data_byte, input status,
                input data_count, output ready);
endinterface

interface dsfd_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/dsfd_front.sv =====
// decoder front: takes wire bytes, unstuffs, checks and forms queue entries
// depends on dsfd_pkg
`timescale 1ns / 1ps

module dsfd_front import dsfd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                use_crc_i,
  input  logic [CAP_BITS-1:0] data_cap_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          wire_byte_i,
  input  logic                buffer_end_i,
  input  logic                q_full_i,
  output logic                push_o,
  output entry_t              entry_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  phase_e                phase_q, phase_d;
  logic [15:0]           crc_q, crc_d;
  logic [7:0]            sum_q, sum_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [2:0]            wcnt_q, wcnt_d;
  status_e               err_q, err_d;
  logic [7:0]            lo_q, lo_d;
  logic                  accept;
  logic                  ovf;
  logic [2:0]            need;
  status_e               verdict;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // data byte overflows at the capacity or at a full counter
  assign ovf = (32'(cnt_q) >= 32'(data_cap_i)) || (cnt_q == COUNT_MAX);

  // decode step for one byte
  always_comb begin
    phase_d = phase_q;
    crc_d   = crc_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    wcnt_d  = (wcnt_q < WIRE_CNT_MAX) ? wcnt_q + 3'd1 : wcnt_q;
    err_d   = err_q;
    lo_d    = lo_q;
    verdict = ST_OK;
    need    = use_crc_i ? MIN_LEN_CRC : MIN_LEN_BCC;
    entry_o = '0;
    entry_o.data_byte = wire_byte_i;

    unique case (phase_q)
      PH_START0: begin
        if (wire_byte_i == DLE_CODE) begin
          phase_d = PH_START1;
        end else begin
          if (err_q == ST_OK) err_d = ST_BADSTART;
          phase_d = PH_DONE;
        end
      end
      PH_START1: begin
        if (wire_byte_i == STX_CODE) begin
          phase_d = PH_DATA;
        end else begin
          if (err_q == ST_OK) err_d = ST_BADSTART;
          phase_d = PH_DONE;
        end
      end
      PH_DATA, PH_ESC: begin
        if (phase_q == PH_DATA && wire_byte_i == DLE_CODE) begin
          phase_d = PH_ESC;
        end else if (phase_q == PH_ESC && wire_byte_i == ETX_CODE) begin
          crc_d   = crc_byte(crc_q, ETX_CODE);
          phase_d = PH_CHK0;
        end else if (phase_q == PH_ESC && wire_byte_i != DLE_CODE) begin
          if (err_q == ST_OK) err_d = ST_BADCTRL;
          phase_d = PH_DONE;
        end else if (ovf) begin
          if (err_q == ST_OK) err_d = ST_OVERFLOW;
          phase_d = PH_DONE;
        end else begin
          entry_o.has_data = 1'b1;
          cnt_d   = cnt_q + 1'b1;
          crc_d   = crc_byte(crc_q, wire_byte_i);
          sum_d   = sum_q + wire_byte_i;
          phase_d = PH_DATA;
        end
      end
      PH_CHK0: begin
        if (use_crc_i) begin
          lo_d    = wire_byte_i;
          phase_d = PH_CHK1;
        end else begin
          if (wire_byte_i != 8'(8'd0 - sum_q) && err_q == ST_OK) err_d = ST_MISMATCH;
          phase_d = PH_DONE;
        end
      end
      PH_CHK1: begin
        if ({wire_byte_i, lo_q} != crc_q && err_q == ST_OK) err_d = ST_MISMATCH;
        phase_d = PH_DONE;
      end
      default: begin
      end
    endcase

    // verdict on the buffer's last byte
    if (wcnt_d < need) begin
      verdict = ST_SHORT;
    end else if (err_d != ST_OK) begin
      verdict = err_d;
    end else if (phase_d == PH_CHK0 || phase_d == PH_CHK1) begin
      verdict = (use_crc_i || phase_d == PH_CHK0) ? ST_NOCHECK : ST_OK;
    end else if (phase_d == PH_DONE) begin
      verdict = ST_OK;
    end else begin
      verdict = ST_NOEND;
    end
    entry_o.has_verdict = buffer_end_i;
    entry_o.status      = verdict;
    entry_o.count       = COUNT_OUT_BITS'(cnt_d);

    // last byte returns everything to the start
    if (buffer_end_i) begin
      phase_d = PH_START0;
      crc_d   = '0;
      sum_d   = '0;
      cnt_d   = '0;
      wcnt_d  = '0;
      err_d   = ST_OK;
      lo_d    = '0;
    end
  end

  assign push_o = accept && (entry_o.has_data || buffer_end_i);

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START0;
      crc_q   <= '0;
      sum_q   <= '0;
      cnt_q   <= '0;
      wcnt_q  <= '0;
      err_q   <= ST_OK;
      lo_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      wcnt_q  <= wcnt_d;
      err_q   <= err_d;
      lo_q    <= lo_d;
    end
  end

endmodule

// ===== hw/rtl/dsfd_queue.sv =====
// small entry queue between decoder front and result emitter
// depends on dsfd_pkg
`timescale 1ns / 1ps

module dsfd_queue import dsfd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t wdata_i,
  input  logic   pop_i,
  output entry_t rdata_o,
  output logic   not_empty_o,
  output logic   full_o
);

  entry_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, rd_q;
  logic [QUEUE_AW:0]   cnt_q;

  assign not_empty_o = cnt_q != '0;
  assign full_o      = cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH);
  assign rdata_o     = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== hw/rtl/dsfd_emit.sv =====
// result emitter: expands queue entries into data and verdict transfers
// depends on dsfd_pkg
`timescale 1ns / 1ps

module dsfd_emit import dsfd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  entry_t                    head_i,
  input  logic                      not_empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      is_verdict_o,
  output logic [7:0]                data_byte_o,
  output logic [2:0]                status_o,
  output logic [COUNT_OUT_BITS-1:0] data_count_o
);

  entry_t cur_q;
  logic   vld_q;
  logic   xfer;
  logic   split;
  logic   done;

  assign xfer  = vld_q && out_ready_i;
  // data byte goes first when an entry holds both
  assign split = cur_q.has_data && cur_q.has_verdict;
  assign done  = xfer && !split;
  assign pop_o = (!vld_q || done) && not_empty_i;

  assign out_valid_o  = vld_q;
  assign is_verdict_o = !cur_q.has_data;
  assign data_byte_o  = cur_q.has_data ? cur_q.data_byte : 8'd0;
  assign status_o     = cur_q.has_data ? 3'(ST_OK) : 3'(cur_q.status);
  assign data_count_o = cur_q.has_data ? '0 : cur_q.count;

  // current entry register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cur_q <= '0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
      cur_q <= head_i;
    end else if (done) begin
      vld_q <= 1'b0;
    end else if (xfer) begin
      cur_q.has_data <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/dle_stuffed_frame_decoder.sv =====
// DLE stuffed frame decoder, top level: front decoder, entry queue, emitter
// depends on dsfd_pkg, dsfd_if, dsfd_front, dsfd_queue, dsfd_emit
`timescale 1ns / 1ps

// The decoder takes one wire byte per cycle on rx_i, checks DLE STX, unstuffs
// doubled DLE, stops data at DLE ETX and checks a BCC or a CRC-16 as use_crc
// selects. Each decoded data byte leaves on res_o as a data transfer; the
// buffer's last byte (buffer_end) yields a verdict transfer with the status
// and the data byte count, after which the decoder is back at the start.
// The front decoder handles one byte per cycle; a four-entry queue holds the
// results of recent bytes, and the emitter sends one transfer per cycle while
// res_o is ready, a data transfer first when a last byte carries both. rx_i
// stalls only when that queue fills. The user must write registers on cfg_i
// only while the block is idle, which it does not enforce; they act at once.
module dle_stuffed_frame_decoder import dsfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsfd_in_if.sink    rx_i,
  dsfd_out_if.source res_o,
  dsfd_cfg_if.sink   cfg_i
);

  logic                use_crc_q;
  logic [CAP_BITS-1:0] data_cap_q;
  logic                push;
  logic                pop;
  logic                q_full;
  logic                q_not_empty;
  entry_t              wr_entry;
  entry_t              head;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_crc_q  <= 1'b0;
      data_cap_q <= '1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_USE_CRC:  use_crc_q  <= cfg_i.data[0];
        CFG_DATA_CAP: data_cap_q <= cfg_i.data[CAP_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  dsfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .use_crc_i    (use_crc_q),
    .data_cap_i   (data_cap_q),
    .in_valid_i   (rx_i.valid),
    .in_ready_o   (rx_i.ready),
    .wire_byte_i  (rx_i.wire_byte),
    .buffer_end_i (rx_i.buffer_end),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (wr_entry)
  );

  dsfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wdata_i     (wr_entry),
    .pop_i       (pop),
    .rdata_o     (head),
    .not_empty_o (q_not_empty),
    .full_o      (q_full)
  );

  dsfd_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .not_empty_i  (q_not_empty),
    .pop_o        (pop),
    .out_valid_o  (res_o.valid),
    .out_ready_i  (res_o.ready),
    .is_verdict_o (res_o.is_verdict),
    .data_byte_o  (res_o.data_byte),
    .status_o     (res_o.status),
    .data_count_o (res_o.data_count)
  );

endmodule
